[hdl/bnu_pkg.sv]
// Shared widths, pipeline payload types and the weight saturation helper
// for the barycentric/normal unit. No dependencies.
package bnu_pkg;

	localparam int CoordBits = 16;
	localparam int FracBits  = 16;
	localparam int NumCoords = 12;

	localparam int EW    = CoordBits + 1;      // edge component
	localparam int PW    = 2 * EW;             // edge product
	localparam int DotW  = PW + 2;             // sum of three products
	localparam int BW    = 2 * DotW;           // product of two dot products
	localparam int DenW  = BW - 3;             // Gram determinant, never negative
	localparam int NumW  = BW - 2;             // signed weight numerator
	localparam int QW    = NumW + FracBits;    // scaled magnitude and quotient
	localparam int VW    = QW + 1;             // signed quotient
	localparam int UW    = QW + 3;             // one minus two quotients
	localparam int OW    = 24;                 // weight output
	localparam int NW    = PW;                 // normal component
	localparam int InW   = NumCoords * CoordBits;
	localparam int OutDW = ((3 * OW + 3 * NW + 7) / 8) * 8;

	typedef struct packed {
		logic            valid;
		logic            degen;
		logic            neg_v;
		logic            neg_w;
		logic [NW-1:0]   nx;
		logic [NW-1:0]   ny;
		logic [NW-1:0]   nz;
	} side_t;

	typedef struct packed {
		side_t           side;
		logic [QW-1:0]   num_v;
		logic [QW-1:0]   num_w;
		logic [DenW-1:0] den;
	} front_t;

	typedef struct packed {
		logic            degen;
		logic [NW-1:0]   nz;
		logic [NW-1:0]   ny;
		logic [NW-1:0]   nx;
		logic [OW-1:0]   w;
		logic [OW-1:0]   v;
		logic [OW-1:0]   u;
	} res_t;

	function automatic logic [OW-1:0] sat_w(input logic [UW-1:0] x);
		logic [OW-1:0] r;
		if (x[UW-1:OW-1] == '0 || x[UW-1:OW-1] == '1) begin
			r = x[OW-1:0];
		end else if (x[UW-1]) begin
			r = {1'b1, {(OW-1){1'b0}}};
		end else begin
			r = {1'b0, {(OW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[hdl/triangle_barycentric_normal_unit.sv]
// Barycentric weights and face normal of a triangle for one query point.
// Pipeline: 7 front stages, 86 divider stages, 1 sign stage and the output buffer write.
// The first stage loads at the accepting edge.
// Throughput: one beat per cycle unless the output buffer is full; the one-bit-per-stage divider sets depth.
// Reset (arst_n low) clears all valid bits and the output buffer at once.
// Depends on bnu_pkg, bnu_front, bnu_div and bnu_obuf.
module triangle_barycentric_normal_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z
	input  logic [bnu_pkg::InW-1:0]    s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// weight_u, weight_v, weight_w, normal_x, normal_y, normal_z, zero pad
	output logic [bnu_pkg::OutDW-1:0]  m_tdata,
	// degenerate
	output logic [0:0]                 m_tuser
);
	localparam int QW = bnu_pkg::QW;
	localparam int VW = bnu_pkg::VW;
	localparam int UW = bnu_pkg::UW;

	logic            en;
	logic            full;
	bnu_pkg::front_t front;
	logic [QW-1:0]   qv, qw;
	bnu_pkg::side_t  side_d [QW+1];
	bnu_pkg::side_t  side_f1;
	logic signed [VW-1:0] v_f1, w_f1;
	logic [UW-1:0]   u_full;
	bnu_pkg::res_t   res;
	bnu_pkg::res_t   head;

	// The whole pipeline advances unless the output buffer is full.
	assign en       = !full;
	assign s_tready = en;

	bnu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.out      (front)
	);

	bnu_div u_div_v (
		.clk  (clk),
		.en   (en),
		.num  (front.num_v),
		.den  (front.den),
		.quot (qv)
	);

	bnu_div u_div_w (
		.clk  (clk),
		.en   (en),
		.num  (front.num_w),
		.den  (front.den),
		.quot (qw)
	);

	assign side_d[0] = front.side;

	for (genvar i = 0; i < QW; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_d[i+1] <= '0;
			end else if (en) begin
				side_d[i+1] <= side_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_f1 <= '0;
		end else if (en) begin
			side_f1 <= side_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_f1 <= side_d[QW].neg_v ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
			w_f1 <= side_d[QW].neg_w ? -$signed({1'b0, qw}) : $signed({1'b0, qw});
		end
	end

	always_comb begin
		u_full    = (UW'(1) << bnu_pkg::FracBits) - UW'(v_f1) - UW'(w_f1);
		res.degen = side_f1.degen;
		res.nx    = side_f1.nx;
		res.ny    = side_f1.ny;
		res.nz    = side_f1.nz;
		if (side_f1.degen) begin
			res.u = bnu_pkg::sat_w(UW'(1) << bnu_pkg::FracBits);
			res.v = '0;
			res.w = '0;
		end else begin
			res.u = bnu_pkg::sat_w(u_full);
			res.v = bnu_pkg::sat_w(UW'(v_f1));
			res.w = bnu_pkg::sat_w(UW'(w_f1));
		end
	end

	bnu_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (side_f1.valid && en),
		.wdata  (res),
		.full   (full),
		.valid  (m_tvalid),
		.rdata  (head),
		.pop    (m_tvalid && m_tready)
	);

	assign m_tdata = bnu_pkg::OutDW'({head.nz, head.ny, head.nx, head.w, head.v, head.u});
	assign m_tuser = head.degen;

endmodule

[hdl/bnu_front.sv]
// Front end: edges, dot and cross products, Gram determinant and scaled
// numerator magnitudes over seven register stages. Uses bnu_pkg.
module bnu_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [bnu_pkg::InW-1:0]   in_data,
	output bnu_pkg::front_t           out
);
	localparam int CW = bnu_pkg::CoordBits;
	localparam int EW = bnu_pkg::EW;
	localparam int PW = bnu_pkg::PW;
	localparam int DotW = bnu_pkg::DotW;
	localparam int BW = bnu_pkg::BW;
	localparam int NW = bnu_pkg::NW;
	localparam int DenW = bnu_pkg::DenW;
	localparam int NumW = bnu_pkg::NumW;
	localparam int QW = bnu_pkg::QW;
	localparam int FracBits = bnu_pkg::FracBits;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [EW-1:0]   e0_s1 [3];
	logic signed [EW-1:0]   e1_s1 [3];
	logic signed [EW-1:0]   ep_s1 [3];
	logic signed [PW-1:0]   p00_s2 [3];
	logic signed [PW-1:0]   p01_s2 [3];
	logic signed [PW-1:0]   p11_s2 [3];
	logic signed [PW-1:0]   pp0_s2 [3];
	logic signed [PW-1:0]   pp1_s2 [3];
	logic signed [PW-1:0]   pc_s2  [6];
	logic signed [DotW-1:0] d00_s3, d01_s3, d11_s3, dp0_s3, dp1_s3;
	logic signed [BW-1:0]   m_s4 [6];
	logic [DenW-1:0]        den_s5, den_s6, den_s7;
	logic signed [NumW-1:0] nv_s5, nw_s5;
	logic [NumW-1:0]        magv_s6, magw_s6;
	logic [QW-1:0]          numv_s7, numw_s7;
	logic                   degen_s5, degen_s6, degen_s7;
	logic                   negv_s6, negw_s6, negv_s7, negw_s7;
	logic [NW-1:0]          n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e0_s1[k] <= EW'($signed(in_data[CW*(3+k) +: CW]))
					- EW'($signed(in_data[CW*k +: CW]));
				e1_s1[k] <= EW'($signed(in_data[CW*(6+k) +: CW]))
					- EW'($signed(in_data[CW*k +: CW]));
				ep_s1[k] <= EW'($signed(in_data[CW*(9+k) +: CW]))
					- EW'($signed(in_data[CW*k +: CW]));
			end

			for (int k = 0; k < 3; k++) begin
				p00_s2[k] <= PW'(e0_s1[k] * e0_s1[k]);
				p01_s2[k] <= PW'(e0_s1[k] * e1_s1[k]);
				p11_s2[k] <= PW'(e1_s1[k] * e1_s1[k]);
				pp0_s2[k] <= PW'(ep_s1[k] * e0_s1[k]);
				pp1_s2[k] <= PW'(ep_s1[k] * e1_s1[k]);
			end
			pc_s2[0] <= PW'(e0_s1[1] * e1_s1[2]);
			pc_s2[1] <= PW'(e0_s1[2] * e1_s1[1]);
			pc_s2[2] <= PW'(e0_s1[2] * e1_s1[0]);
			pc_s2[3] <= PW'(e0_s1[0] * e1_s1[2]);
			pc_s2[4] <= PW'(e0_s1[0] * e1_s1[1]);
			pc_s2[5] <= PW'(e0_s1[1] * e1_s1[0]);

			d00_s3 <= DotW'(p00_s2[0]) + DotW'(p00_s2[1]) + DotW'(p00_s2[2]);
			d01_s3 <= DotW'(p01_s2[0]) + DotW'(p01_s2[1]) + DotW'(p01_s2[2]);
			d11_s3 <= DotW'(p11_s2[0]) + DotW'(p11_s2[1]) + DotW'(p11_s2[2]);
			dp0_s3 <= DotW'(pp0_s2[0]) + DotW'(pp0_s2[1]) + DotW'(pp0_s2[2]);
			dp1_s3 <= DotW'(pp1_s2[0]) + DotW'(pp1_s2[1]) + DotW'(pp1_s2[2]);
			for (int k = 0; k < 3; k++) begin
				// Each cross term difference stays inside the normal width.
				n_s3[k] <= NW'(pc_s2[2*k] - pc_s2[2*k+1]);
			end

			m_s4[0] <= BW'(d00_s3 * d11_s3);
			m_s4[1] <= BW'(d01_s3 * d01_s3);
			m_s4[2] <= BW'(d11_s3 * dp0_s3);
			m_s4[3] <= BW'(d01_s3 * dp1_s3);
			m_s4[4] <= BW'(d00_s3 * dp1_s3);
			m_s4[5] <= BW'(d01_s3 * dp0_s3);
			n_s4 <= n_s3;

			den_s5   <= DenW'(m_s4[0] - m_s4[1]);
			degen_s5 <= (m_s4[0] == m_s4[1]);
			nv_s5    <= NumW'(m_s4[2] - m_s4[3]);
			nw_s5    <= NumW'(m_s4[4] - m_s4[5]);
			n_s5     <= n_s4;

			negv_s6  <= nv_s5[NumW-1];
			negw_s6  <= nw_s5[NumW-1];
			magv_s6  <= nv_s5[NumW-1] ? NumW'(-nv_s5) : NumW'(nv_s5);
			magw_s6  <= nw_s5[NumW-1] ? NumW'(-nw_s5) : NumW'(nw_s5);
			den_s6   <= den_s5;
			degen_s6 <= degen_s5;
			n_s6     <= n_s5;

			// Scale by the fraction bits and add half the divisor for rounding.
			numv_s7  <= {magv_s6, {FracBits{1'b0}}} + QW'(den_s6 >> 1);
			numw_s7  <= {magw_s6, {FracBits{1'b0}}} + QW'(den_s6 >> 1);
			negv_s7  <= negv_s6;
			negw_s7  <= negw_s6;
			den_s7   <= den_s6;
			degen_s7 <= degen_s6;
			n_s7     <= n_s6;
		end
	end

	always_comb begin
		out.side.valid = v_s7;
		out.side.degen = degen_s7;
		out.side.neg_v = negv_s7;
		out.side.neg_w = negw_s7;
		out.side.nx    = n_s7[0];
		out.side.ny    = n_s7[1];
		out.side.nz    = n_s7[2];
		out.num_v      = numv_s7;
		out.num_w      = numw_s7;
		out.den        = den_s7;
	end

endmodule

[hdl/bnu_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Uses bnu_pkg for the numerator and divisor widths.
module bnu_div (
	input  logic                    clk,
	input  logic                    en,
	input  logic [bnu_pkg::QW-1:0]  num,
	input  logic [bnu_pkg::DenW-1:0] den,
	output logic [bnu_pkg::QW-1:0]  quot
);
	localparam int QW = bnu_pkg::QW;
	localparam int DenW = bnu_pkg::DenW;

	// The numerator shifts out at the top while quotient bits shift in below.
	logic [DenW-1:0] rem_s [QW+1];
	logic [QW-1:0]   nq_s  [QW+1];
	logic [DenW-1:0] den_s [QW+1];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign den_s[0] = den;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DenW:0] trial;
		logic [DenW:0] diff;
		logic          ge;

		always_comb begin
			trial = {rem_s[i], nq_s[i][QW-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = (trial >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
				nq_s[i+1]  <= {nq_s[i][QW-2:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign quot = nq_s[QW];

endmodule

[hdl/bnu_obuf.sv]
// Two-entry output buffer that decouples the pipeline advance from the
// downstream ready. Uses bnu_pkg::res_t.
module bnu_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bnu_pkg::res_t wdata,
	output logic          full,
	output logic          valid,
	output bnu_pkg::res_t rdata,
	input  logic          pop
);
	bnu_pkg::res_t mem_q [2];
	logic [1:0]    count_q;
	logic          wr_q, rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign rdata = mem_q[rd_q];

endmodule

[hdl/bnu_chk.sv]
// Port-level checker for the barycentric/normal unit and its bind.
// Depends on bnu_pkg and triangle_barycentric_normal_unit.
module bnu_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [bnu_pkg::InW-1:0]   s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bnu_pkg::OutDW-1:0] m_tdata,
	input logic [0:0]                m_tuser
);
	// A result beat that is not taken stays, unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// The input only stalls when results are waiting downstream.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// A degenerate triangle reports u = 1.0, v = 0, w = 0.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
		m_tdata[23:0] == 24'h010000 && m_tdata[71:24] == 48'h0)
		else $error("degenerate weights wrong");

	// Reset, once sampled low, must clear any offered result beat.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result beat right after reset");

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind triangle_barycentric_normal_unit bnu_chk u_bnu_chk (.*);

[sim/triangle_barycentric_normal_unit_test.sv]
// Self-checking bench for triangle_barycentric_normal_unit: random and corner-case
// triangles go in as beats, and a predictor computes the weights and normals to compare against.
// Depends on bnu_pkg and the unit's RTL.
module triangle_barycentric_normal_unit_test;

	typedef struct packed {
		logic        degen;
		logic [33:0] nz;
		logic [33:0] ny;
		logic [33:0] nx;
		logic [23:0] w;
		logic [23:0] v;
		logic [23:0] u;
	} bary_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [bnu_pkg::InW-1:0]     s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [bnu_pkg::OutDW-1:0]   m_tdata;
	logic [0:0]                  m_tuser;

	bary_t               expected_q[$];
	int                  mismatches = 0;
	int                  idle_cycles = 0;
	bit                  hold_off = 1'b0;
	bit                  gaps_on = 1'b1;

	always #2 clk = ~clk;

	triangle_barycentric_normal_unit u_dut (.*);

	function automatic logic signed [23:0] sat24(logic signed [127:0] x);
		if (x > 128'sd8388607) return 24'sh7fffff;
		if (x < -128'sd8388608) return 24'sh800000;
		return x[23:0];
	endfunction

	function automatic logic signed [33:0] sat34(logic signed [63:0] x);
		if (x > 64'sd8589934591) return {1'b0, {33{1'b1}}};
		if (x < -64'sd8589934592) return {1'b1, {33{1'b0}}};
		return x[33:0];
	endfunction

	// Rounded num * 2^16 / den, ties away from zero; den is positive.
	function automatic logic signed [127:0] scaled_quot(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] mag;
		logic signed [127:0] q;
		mag = (num < 0) ? -num : num;
		q = ((mag <<< 16) + (den >>> 1)) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic bary_t predict_bary(logic [bnu_pkg::InW-1:0] d);
		logic signed [63:0] crd[12];
		logic signed [63:0] e0[3], e1[3], ep[3];
		logic signed [63:0] d00, d01, d11, dp0, dp1;
		logic signed [127:0] den, vq, wq, one;
		bary_t r;
		for (int i = 0; i < 12; i++) crd[i] = $signed(d[16*i +: 16]);
		for (int i = 0; i < 3; i++) begin
			e0[i] = crd[3+i] - crd[i];
			e1[i] = crd[6+i] - crd[i];
			ep[i] = crd[9+i] - crd[i];
		end
		d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
		d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
		d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
		dp0 = ep[0]*e0[0] + ep[1]*e0[1] + ep[2]*e0[2];
		dp1 = ep[0]*e1[0] + ep[1]*e1[1] + ep[2]*e1[2];
		den = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
		one = 128'sd65536;
		if (den <= 0) begin
			r.u = sat24(one);
			r.v = '0;
			r.w = '0;
			r.degen = 1'b1;
		end else begin
			vq = scaled_quot(128'(d11)*128'(dp0) - 128'(d01)*128'(dp1), den);
			wq = scaled_quot(128'(d00)*128'(dp1) - 128'(d01)*128'(dp0), den);
			r.u = sat24(one - vq - wq);
			r.v = sat24(vq);
			r.w = sat24(wq);
			r.degen = 1'b0;
		end
		r.nx = sat34(e0[1]*e1[2] - e0[2]*e1[1]);
		r.ny = sat34(e0[2]*e1[0] - e0[0]*e1[2]);
		r.nz = sat34(e0[0]*e1[1] - e0[1]*e1[0]);
		return r;
	endfunction

	// Sends one beat, on some beats with a gap of random length first when gaps are enabled.
	task automatic send_triangle(logic [bnu_pkg::InW-1:0] d);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(predict_bary(d));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord(bit narrow);
		if (narrow) return 16'($signed($urandom_range(0, 1023)) - 512);
		return 16'($urandom);
	endfunction

	function automatic logic [bnu_pkg::InW-1:0] rand_triangle();
		logic [bnu_pkg::InW-1:0] d;
		bit narrow;
		narrow = $urandom_range(0, 1);
		for (int i = 0; i < 12; i++) d[16*i +: 16] = rand_coord(narrow);
		// Some coincident or collinear vertices to hit the degenerate path, or the point on vertex a.
		case ($urandom_range(0, 9))
			0: d[96 +: 48] = d[0 +: 48];
			1: d[48 +: 48] = d[0 +: 48];
			2: for (int i = 0; i < 3; i++)
				d[96+16*i +: 16] = 16'(2 * $signed(d[48+16*i +: 16]) - $signed(d[16*i +: 16]));
			3: d[144 +: 48] = d[0 +: 48];
			default: ;
		endcase
		return d;
	endfunction

	task automatic test_directed();
		logic [bnu_pkg::InW-1:0] d;
		send_triangle('0);
		send_triangle('1);
		send_triangle({12{16'h7fff}});
		send_triangle({12{16'h8000}});
		for (int k = 0; k < 8; k++) begin
			for (int i = 0; i < 12; i++) d[16*i +: 16] = k[i % 3] ? 16'h7fff : 16'h8000;
			d[48 +: 16] = ~d[48 +: 16];
			d[112 +: 16] = ~d[112 +: 16];
			send_triangle(d);
		end
		// Right triangle with legs of 0x100, the point at vertices a and b and then outside.
		d = '0;
		d[48 +: 16] = 16'h0100;
		d[112 +: 16] = 16'h0100;
		send_triangle(d);
		d[144 +: 16] = 16'h0100;
		send_triangle(d);
		d[144 +: 16] = 16'h7fff;
		d[160 +: 16] = 16'h7fff;
		send_triangle(d);
		d[144 +: 16] = 16'h8000;
		send_triangle(d);
		// Tiny triangle with a far point drives the weights into saturation.
		d = '0;
		d[48 +: 16] = 16'h0001;
		d[112 +: 16] = 16'h0001;
		d[144 +: 32] = {16'h7fff, 16'h8000};
		send_triangle(d);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) send_triangle(rand_triangle());
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering beats.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 200; n++) send_triangle(rand_triangle());
		join
		gaps_on = 1'b1;
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (!arst_n || hold_off) m_tready <= 1'b0;
		else case ($urandom_range(0, 2))
			0: m_tready <= ($urandom_range(0, 3) != 0);
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		bary_t got, exp_r;
		if (m_tvalid && m_tready) begin
			got = '{degen: m_tuser[0], nz: m_tdata[140 +: 34], ny: m_tdata[106 +: 34],
				nx: m_tdata[72 +: 34], w: m_tdata[48 +: 24], v: m_tdata[24 +: 24],
				u: m_tdata[0 +: 24]};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("u %h/%h v %h/%h w %h/%h n %h %h %h/%h %h %h deg %b/%b",
							exp_r.u, got.u, exp_r.v, got.v, exp_r.w, got.w,
							exp_r.nx, exp_r.ny, exp_r.nz, got.nx, got.ny, got.nz,
							exp_r.degen, got.degen);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(350);
		test_backpressure();
		test_random(330);
		repeat (120) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/bnu_pkg.sv
hdl/bnu_front.sv
hdl/bnu_div.sv
hdl/bnu_obuf.sv
hdl/triangle_barycentric_normal_unit.sv
hdl/bnu_chk.sv
sim/triangle_barycentric_normal_unit_test.sv
